/* src/mfwq_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Mutex with FIFO handoff: shared definitions
// Operation codes, status codes, field widths and parameter defaults.
// ----------------------------------------------------------------------------
package mfwq_pkg;

  localparam int KIND_W   = 2;
  localparam int REQ_W    = 8;
  localparam int STATUS_W = 3;

  localparam int WAIT_DEPTH_DEF = 16;
  localparam int ID_WIDTH_DEF   = 8;

  localparam logic [KIND_W-1:0] KIND_LOCK    = 2'd0;
  localparam logic [KIND_W-1:0] KIND_TRYLOCK = 2'd1;
  localparam logic [KIND_W-1:0] KIND_UNLOCK  = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK          = 3'd0;
  localparam logic [STATUS_W-1:0] ST_QUEUED      = 3'd1;
  localparam logic [STATUS_W-1:0] ST_AT_HEAD     = 3'd2;
  localparam logic [STATUS_W-1:0] ST_TRY_REFUSED = 3'd3;
  localparam logic [STATUS_W-1:0] ST_UNL_REFUSED = 3'd4;
  localparam logic [STATUS_W-1:0] ST_QUEUE_FULL  = 3'd5;

endpackage

`default_nettype wire

/* src/mfwq_if.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Mutex with FIFO handoff: channel interfaces
// Valid/ready channels for the operation items and the result items.
// ----------------------------------------------------------------------------
interface mfwq_cmd_if
  import mfwq_pkg::*;
  ();
  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] kind;
  logic [REQ_W-1:0]  requester;

  modport source (output valid, output kind, output requester, input ready);
  modport sink   (input valid, input kind, input requester, output ready);
endinterface

interface mfwq_rsp_if
  import mfwq_pkg::*;
  ();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic                wake_valid;
  logic [REQ_W-1:0]    wake_id;

  modport source (output valid, output status, output wake_valid, output wake_id,
                  input ready);
  modport sink   (input valid, input status, input wake_valid, input wake_id,
                  output ready);
endinterface

`default_nettype wire

/* src/mutex_fifo_wait_queue.sv */
`timescale 1ns / 1ps
`default_nettype none
// A result is registered when its item executes in EXEC after acceptance; a
// result not yet taken holds EXEC. Items are taken only in IDLE, once the last
// is done; the head is read synchronously from the wait memory on acceptance.
// Reset: synchronous, clears the lock, owner, pointers and count at once;
// the wait memory is not cleared, since only written entries are ever read.
// ----------------------------------------------------------------------------
// Mutex with FIFO handoff
// One lock with an owner and a memory-based FIFO of waiting requester ids.
// ----------------------------------------------------------------------------
module mutex_fifo_wait_queue
  import mfwq_pkg::*;
#(
  parameter int WAIT_DEPTH = WAIT_DEPTH_DEF,
  parameter int ID_WIDTH   = ID_WIDTH_DEF
) (
  input  wire logic   clk,
  input  wire logic   rst,
  mfwq_cmd_if.sink    cmd,
  mfwq_rsp_if.source  rsp
);

  localparam int IdW  = (ID_WIDTH < REQ_W) ? ID_WIDTH : REQ_W;
  localparam int PtrW = (WAIT_DEPTH > 1) ? $clog2(WAIT_DEPTH) : 1;
  localparam int CntW = $clog2(WAIT_DEPTH + 1);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EXEC = 1'b1;

  logic [IdW-1:0]  wait_mem [WAIT_DEPTH];
  logic [IdW-1:0]  head_data;

  logic            state;
  logic            locked;
  logic [IdW-1:0]  owner_id;
  logic [PtrW-1:0] fifo_head;
  logic [PtrW-1:0] fifo_tail;
  logic [CntW-1:0] fifo_count;
  logic [KIND_W-1:0] op_kind;
  logic [IdW-1:0]  op_req;

  logic                out_valid;
  logic [STATUS_W-1:0] out_status;
  logic                out_wake_valid;
  logic [IdW-1:0]      out_wake_id;

  logic            locked_next;
  logic [IdW-1:0]  owner_id_next;
  logic [PtrW-1:0] fifo_head_next;
  logic [PtrW-1:0] fifo_tail_next;
  logic [CntW-1:0] fifo_count_next;
  logic [STATUS_W-1:0] status_next;
  logic            wake_valid_next;
  logic            mem_we;

  logic accept;
  logic fire;
  logic head_hit;
  logic queue_full;

  assign accept = cmd.valid && cmd.ready;
  assign fire   = (state == ST_EXEC) && (!out_valid || rsp.ready);

  assign cmd.ready      = (state == ST_IDLE);
  assign rsp.valid      = out_valid;
  assign rsp.status     = out_status;
  assign rsp.wake_valid = out_wake_valid;
  assign rsp.wake_id    = REQ_W'(out_wake_id);

  assign head_hit   = (fifo_count != '0) && (head_data == op_req);
  assign queue_full = (fifo_count == CntW'(WAIT_DEPTH));

  function automatic logic [PtrW-1:0] next_slot(input logic [PtrW-1:0] p);
    next_slot = (p == PtrW'(WAIT_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_comb begin
    locked_next     = locked;
    owner_id_next   = owner_id;
    fifo_head_next  = fifo_head;
    fifo_tail_next  = fifo_tail;
    fifo_count_next = fifo_count;
    status_next     = ST_OK;
    wake_valid_next = 1'b0;
    mem_we          = 1'b0;
    unique case (op_kind)
      KIND_LOCK: begin
        if (!locked || op_req == owner_id) begin
          locked_next   = 1'b1;
          owner_id_next = op_req;
        end else if (head_hit) begin
          status_next = ST_AT_HEAD;
        end else if (queue_full) begin
          status_next = ST_QUEUE_FULL;
        end else begin
          mem_we          = 1'b1;
          fifo_tail_next  = next_slot(fifo_tail);
          fifo_count_next = fifo_count + 1'b1;
          status_next     = ST_QUEUED;
        end
      end
      KIND_TRYLOCK: begin
        if (locked) begin
          status_next = ST_TRY_REFUSED;
        end else begin
          locked_next   = 1'b1;
          owner_id_next = op_req;
        end
      end
      KIND_UNLOCK: begin
        if (locked && owner_id == op_req) begin
          if (fifo_count == '0) begin
            locked_next   = 1'b0;
            owner_id_next = '0;
          end else begin
            owner_id_next   = head_data;
            fifo_head_next  = next_slot(fifo_head);
            fifo_count_next = fifo_count - 1'b1;
            wake_valid_next = 1'b1;
          end
        end else begin
          status_next = ST_UNL_REFUSED;
        end
      end
      default: begin
        status_next = ST_OK;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      head_data <= wait_mem[fifo_head];
    end
    if (fire && mem_we) begin
      wait_mem[fifo_tail] <= op_req;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_kind <= cmd.kind;
      op_req  <= cmd.requester[IdW-1:0];
    end
    if (fire) begin
      out_status     <= status_next;
      out_wake_valid <= wake_valid_next;
      out_wake_id    <= wake_valid_next ? head_data : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      locked     <= 1'b0;
      owner_id   <= '0;
      fifo_head  <= '0;
      fifo_tail  <= '0;
      fifo_count <= '0;
      out_valid  <= 1'b0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            state <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          if (fire) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
      if (fire) begin
        locked     <= locked_next;
        owner_id   <= owner_id_next;
        fifo_head  <= fifo_head_next;
        fifo_tail  <= fifo_tail_next;
        fifo_count <= fifo_count_next;
        out_valid  <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

/* verif/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Mutex with FIFO handoff: regression testbench
// Drives lock, trylock and unlock items through the command channel and checks
// every result item against a cycle-free model of the lock, its owner and its
// queue of waiters, or against a directed item's fixed reply. A short table
// of directed items comes first. Random items follow in three phases of sender
// and receiver idling, and the last phase includes one long receiver hold-off.
// ----------------------------------------------------------------------------
module testbench;
  import mfwq_pkg::*;

  localparam int WAIT_DEPTH      = WAIT_DEPTH_DEF;
  localparam int PTR_W           = $clog2(WAIT_DEPTH);
  localparam int ITEMS_PER_PHASE = 512;
  localparam int POOL_SIZE       = 6;
  localparam int HOLD_CYCLES     = 80;
  localparam int STALL_LIMIT     = 2000;
  localparam int DRAIN_CYCLES    = 8;

  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic                wake_valid;
    logic [REQ_W-1:0]    wake_id;
  } lock_reply_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [REQ_W-1:0]  requester;
    logic              fixed;
    lock_reply_t       reply;
  } lock_op_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  mfwq_cmd_if cmd ();
  mfwq_rsp_if rsp ();

  mutex_fifo_wait_queue dut (
    .clk (clk),
    .rst (rst),
    .cmd (cmd),
    .rsp (rsp)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  logic              held = 1'b0;
  logic [REQ_W-1:0]  owner = '0;
  logic [REQ_W-1:0]  wait_ids [WAIT_DEPTH];
  logic [PTR_W-1:0]  wait_head = '0;
  logic [PTR_W-1:0]  wait_tail = '0;
  int                wait_count = 0;

  lock_reply_t       replies_due [$];
  logic [REQ_W-1:0]  id_pool [POOL_SIZE];
  int                mismatch_count = 0;
  int                replies_seen = 0;
  int                stall_cycles = 0;
  int                src_idle_pct = 0;
  int                snk_idle_pct = 0;
  int                phase = 0;
  logic              long_hold_done = 1'b0;

  lock_op_t directed_ops [16] = '{
    '{KIND_UNLOCK,  8'h00, 1'b1, '{ST_UNL_REFUSED, 1'b0, 8'h00}},
    '{KIND_TRYLOCK, 8'hFF, 1'b1, '{ST_OK,          1'b0, 8'h00}},
    '{KIND_TRYLOCK, 8'hFF, 1'b1, '{ST_TRY_REFUSED, 1'b0, 8'h00}},
    '{KIND_LOCK,    8'hFF, 1'b1, '{ST_OK,          1'b0, 8'h00}},
    '{KIND_UNUSED,  8'hAA, 1'b1, '{ST_OK,          1'b0, 8'h00}},
    '{KIND_LOCK,    8'h00, 1'b1, '{ST_QUEUED,      1'b0, 8'h00}},
    '{KIND_LOCK,    8'h00, 1'b1, '{ST_AT_HEAD,     1'b0, 8'h00}},
    '{KIND_LOCK,    8'h55, 1'b1, '{ST_QUEUED,      1'b0, 8'h00}},
    '{KIND_LOCK,    8'h55, 1'b1, '{ST_QUEUED,      1'b0, 8'h00}},
    '{KIND_UNLOCK,  8'h00, 1'b1, '{ST_UNL_REFUSED, 1'b0, 8'h00}},
    '{KIND_UNLOCK,  8'hFF, 1'b1, '{ST_OK,          1'b1, 8'h00}},
    '{KIND_TRYLOCK, 8'h80, 1'b1, '{ST_TRY_REFUSED, 1'b0, 8'h00}},
    '{KIND_UNLOCK,  8'h00, 1'b1, '{ST_OK,          1'b1, 8'h55}},
    '{KIND_UNLOCK,  8'h55, 1'b1, '{ST_OK,          1'b1, 8'h55}},
    '{KIND_UNLOCK,  8'h55, 1'b1, '{ST_OK,          1'b0, 8'h00}},
    '{KIND_LOCK,    8'h10, 1'b0, '{ST_OK,          1'b0, 8'h00}}
  };

  function automatic lock_reply_t mutex_apply(logic [KIND_W-1:0] kind,
                                              logic [REQ_W-1:0] req);
    lock_reply_t r;
    r = '0;
    r.status = ST_OK;
    case (kind)
      KIND_LOCK: begin
        if (!held || req == owner) begin
          held = 1'b1;
          owner = req;
        end else if (wait_count != 0 && wait_ids[wait_head] == req) begin
          r.status = ST_AT_HEAD;
        end else if (wait_count >= WAIT_DEPTH) begin
          r.status = ST_QUEUE_FULL;
        end else begin
          wait_ids[wait_tail] = req;
          wait_tail = wait_tail + 1'b1;
          wait_count++;
          r.status = ST_QUEUED;
        end
      end
      KIND_TRYLOCK: begin
        if (held) begin
          r.status = ST_TRY_REFUSED;
        end else begin
          held = 1'b1;
          owner = req;
        end
      end
      KIND_UNLOCK: begin
        if (held && owner == req) begin
          if (wait_count == 0) begin
            held = 1'b0;
            owner = '0;
          end else begin
            owner = wait_ids[wait_head];
            wait_head = wait_head + 1'b1;
            wait_count--;
            r.wake_valid = 1'b1;
            r.wake_id = owner;
          end
        end else begin
          r.status = ST_UNL_REFUSED;
        end
      end
      default: begin
      end
    endcase
    return r;
  endfunction

  function automatic lock_op_t random_op();
    lock_op_t op;
    int roll;
    op = '0;
    roll = $urandom_range(0, 99);
    op.requester = id_pool[$urandom_range(0, POOL_SIZE - 1)];
    if (roll < 32) begin
      op.kind = KIND_LOCK;
    end else if (roll < 40) begin
      op.kind = KIND_LOCK;
      if (wait_count != 0) op.requester = wait_ids[wait_head];
    end else if (roll < 48) begin
      op.kind = KIND_TRYLOCK;
    end else if (roll < 86) begin
      op.kind = KIND_UNLOCK;
      if (held) op.requester = owner;
    end else if (roll < 94) begin
      op.kind = KIND_UNLOCK;
    end else if (roll < 97) begin
      op.kind = KIND_UNUSED;
      op.requester = REQ_W'($urandom_range(0, 255));
    end else begin
      op.kind = KIND_W'($urandom_range(0, 3));
      op.requester = REQ_W'($urandom_range(0, 255));
    end
    return op;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch in result %0d: %s is %0d, expected %0d",
             replies_seen, what, got, want);
    mismatch_count++;
  endtask

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_op(lock_op_t op);
    lock_reply_t predicted;
    while ($urandom_range(0, 99) < src_idle_pct) begin
      cmd.valid = 1'b0;
      @(negedge clk);
    end
    cmd.valid = 1'b1;
    cmd.kind = op.kind;
    cmd.requester = op.requester;
    @(posedge clk);
    while (!cmd.ready) @(posedge clk);
    predicted = mutex_apply(op.kind, op.requester);
    replies_due.push_back(op.fixed ? op.reply : predicted);
    @(negedge clk);
  endtask

  initial begin
    rsp.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (phase == 2 && !long_hold_done) begin
        long_hold_done = 1'b1;
        rsp.ready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end else begin
        rsp.ready = ($urandom_range(0, 99) >= snk_idle_pct);
      end
    end
  end

  always @(posedge clk) begin : check_replies
    lock_reply_t want;
    if (!rst && rsp.valid && rsp.ready) begin
      replies_seen++;
      if (replies_due.size() == 0) begin
        report_mismatch("unexpected result, status", rsp.status, -1);
      end else begin
        want = replies_due.pop_front();
        if (rsp.status !== want.status)
          report_mismatch("status", rsp.status, want.status);
        if (rsp.wake_valid !== want.wake_valid)
          report_mismatch("wake_valid", rsp.wake_valid, want.wake_valid);
        if (rsp.wake_id !== want.wake_id)
          report_mismatch("wake_id", rsp.wake_id, want.wake_id);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (cmd.valid && cmd.ready) || (rsp.valid && rsp.ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= STALL_LIMIT) begin
      $display("watchdog: no item moved for %0d cycles", STALL_LIMIT);
      $display("mutex_fifo_wait_queue regression: fail");
      $finish;
    end
  end

  initial begin
    lock_op_t op;
    cmd.valid = 1'b0;
    cmd.kind = KIND_LOCK;
    cmd.requester = '0;
    src_idle_pct = 28;
    snk_idle_pct = 60;
    repeat (12) @(negedge clk);
    rst = 1'b0;

    foreach (directed_ops[i]) send_op(directed_ops[i]);
    op = '0;
    op.kind = KIND_LOCK;
    for (int i = 1; i <= WAIT_DEPTH; i++) begin
      op.requester = REQ_W'(8'h10 + i);
      send_op(op);
    end
    op.requester = 8'hF0;
    op.fixed = 1'b1;
    op.reply = '{ST_QUEUE_FULL, 1'b0, 8'h00};
    send_op(op);

    for (int p = 0; p < 3; p++) begin
      phase = p;
      src_idle_pct = (p == 0) ? 28 : (p == 1) ? 60 : 0;
      snk_idle_pct = (p == 0) ? 60 : (p == 1) ? 28 : 0;
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        if (n % 64 == 0) begin
          foreach (id_pool[k]) id_pool[k] = REQ_W'($urandom_range(0, 255));
        end
        send_op(random_op());
      end
    end
    cmd.valid = 1'b0;

    while (replies_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("mutex_fifo_wait_queue regression: pass");
    end else begin
      $display("mutex_fifo_wait_queue regression: fail");
    end
    $finish;
  end

endmodule

/* filelist.f */
src/mfwq_pkg.sv
src/mfwq_if.sv
src/mutex_fifo_wait_queue.sv
verif/testbench.sv
